### src/bmle_pkg.sv
// Package for the bounded multi-list engine: opcodes, status codes, state
// encodings and the controller/datapath command structs. No dependencies.
package bmle_pkg;

  localparam int NumListsDefault    = 10;
  localparam int MaxCapacityDefault = 16;

  localparam logic [2:0] OpCreate = 3'd0;
  localparam logic [2:0] OpAppend = 3'd1;
  localparam logic [2:0] OpPop    = 3'd2;
  localparam logic [2:0] OpDelete = 3'd3;
  localparam logic [2:0] OpResize = 3'd4;
  localparam logic [2:0] OpCount  = 3'd5;
  localparam logic [2:0] OpRead   = 3'd6;
  localparam logic [2:0] OpSorted = 3'd7;

  localparam logic [3:0] StOk         = 4'd0;
  localparam logic [3:0] StBadPos     = 4'd1;
  localparam logic [3:0] StExists     = 4'd2;
  localparam logic [3:0] StBadSize    = 4'd3;
  localparam logic [3:0] StNoMemory   = 4'd4;
  localparam logic [3:0] StNoList     = 4'd5;
  localparam logic [3:0] StFull       = 4'd6;
  localparam logic [3:0] StEmpty      = 4'd7;
  localparam logic [3:0] StNotFound   = 4'd8;
  localparam logic [3:0] StBadNewSize = 4'd9;

  typedef enum logic [3:0] {
    S_IDLE,     // waiting for start
    S_DECIDE,   // checks done on latched item, single-result ops finish here
    S_SEARCH,   // delete: scan for a match, one entry a cycle
    S_SHIFT,    // delete: move later entries down, one a cycle
    S_COPY,     // readout: copy the list into the sort buffer
    S_SORT,     // sorted readout: one compare/swap a cycle
    S_EMIT      // readout: one element a cycle
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch;      // capture the input item
    logic decide;     // perform single-result operation and emit
    logic idx_clr;    // clear the walk index
    logic idx_inc;    // advance the walk index
    logic rd_req;     // issue a memory read at the walk index
    logic shift_wr;   // write previous read data one entry down
    logic del_done;   // commit fill-1 and emit ok
    logic nf_emit;    // emit not found
    logic buf_wr;     // write read data into the sort buffer
    logic sort_init;  // set up the compare pair
    logic sort_step;  // one compare/swap
    logic emit;       // emit one buffer entry
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] op;
    logic       go_multi;  // latched item needs a multi-cycle walk
    logic       match;     // read data equals value (valid after rd_req)
    logic       rd_valid;  // read data is valid
    logic       idx_end;   // walk index at fill - 1
    logic       sort_end;  // last compare pair reached
    logic       emit_end;  // emitting the final element
  } stat_t;

endpackage

### src/bounded_multi_list_engine.sv
// Top level of the bounded multi-list engine: controller plus datapath.
// Depends on bmle_pkg, bmle_ctrl and bmle_dp.

// Items are taken when start is high and busy is low. Each result is shown
// for one cycle with result_valid_o; the receiver cannot stall it. A
// single-result operation keeps busy high for one cycle, and its result shows
// in the next cycle, when a new item can already be taken. Delete walks the
// list through the element memory port, one entry a cycle, and keeps busy
// high until the walk ends. A readout decides and then copies the list into
// the sort buffer; a sorted readout then runs its compare/swap pass, and fill
// results follow on consecutive cycles.
module bounded_multi_list_engine #(
  parameter int NumLists    = bmle_pkg::NumListsDefault,
  parameter int MaxCapacity = bmle_pkg::MaxCapacityDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode_i,
  input  logic [3:0]         list_number_i,
  input  logic signed [31:0] value_i,
  input  logic signed [6:0]  amount_i,
  output logic               result_valid_o,
  output logic [3:0]         status_o,
  output logic [4:0]         fill_count_o,
  output logic signed [31:0] data_o,
  output logic               last_o
);

  bmle_pkg::ctrl_t ctrl;
  bmle_pkg::stat_t stat;

  bmle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  bmle_dp #(
    .NumLists   (NumLists),
    .MaxCapacity(MaxCapacity)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .list_number_i (list_number_i),
    .value_i       (value_i),
    .amount_i      (amount_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .fill_count_o  (fill_count_o),
    .data_o        (data_o),
    .last_o        (last_o)
  );

endmodule

### src/bmle_ctrl.sv
// Controller for the bounded multi-list engine.
// Depends on bmle_pkg for the state enum and command/status structs.
module bmle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bmle_pkg::stat_t  stat_i,
  output bmle_pkg::ctrl_t  ctrl_o,
  output logic             busy_o
);

  bmle_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmle_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bmle_pkg::S_IDLE: begin
        if (start_i) state_d = bmle_pkg::S_DECIDE;
      end
      bmle_pkg::S_DECIDE: begin
        if (!stat_i.go_multi) begin
          state_d = bmle_pkg::S_IDLE;
        end else if (stat_i.op == bmle_pkg::OpDelete) begin
          state_d = bmle_pkg::S_SEARCH;
        end else begin
          state_d = bmle_pkg::S_COPY;
        end
      end
      bmle_pkg::S_SEARCH: begin
        // The final entry ends the search: a match there needs no shift, else not found.
        if (stat_i.rd_valid && stat_i.idx_end) begin
          state_d = bmle_pkg::S_IDLE;
        end else if (stat_i.rd_valid && stat_i.match) begin
          state_d = bmle_pkg::S_SHIFT;
        end
      end
      bmle_pkg::S_SHIFT: begin
        if (stat_i.idx_end) state_d = bmle_pkg::S_IDLE;
      end
      bmle_pkg::S_COPY: begin
        if (stat_i.rd_valid && stat_i.idx_end) begin
          state_d = (stat_i.op == bmle_pkg::OpSorted) ? bmle_pkg::S_SORT
                                                       : bmle_pkg::S_EMIT;
        end
      end
      bmle_pkg::S_SORT: begin
        if (stat_i.sort_end) state_d = bmle_pkg::S_EMIT;
      end
      bmle_pkg::S_EMIT: begin
        if (stat_i.emit_end) state_d = bmle_pkg::S_IDLE;
      end
      default: state_d = bmle_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b1;
    case (state_q)
      bmle_pkg::S_IDLE: begin
        busy_o       = 1'b0;
        ctrl_o.latch = start_i;
      end
      bmle_pkg::S_DECIDE: begin
        ctrl_o.decide  = 1'b1;
        ctrl_o.idx_clr = 1'b1;
        ctrl_o.rd_req  = stat_i.go_multi;
      end
      bmle_pkg::S_SEARCH: begin
        // A read is issued each cycle; the returned data is for the current index.
        if (stat_i.rd_valid && stat_i.match) begin
          if (stat_i.idx_end) begin
            ctrl_o.del_done = 1'b1;
          end else begin
            ctrl_o.idx_inc = 1'b1;
            ctrl_o.rd_req  = 1'b1;
          end
        end else if (stat_i.rd_valid && stat_i.idx_end) begin
          ctrl_o.nf_emit = 1'b1;
        end else if (stat_i.rd_valid) begin
          ctrl_o.idx_inc = 1'b1;
          ctrl_o.rd_req  = 1'b1;
        end
      end
      bmle_pkg::S_SHIFT: begin
        if (stat_i.rd_valid) begin
          ctrl_o.shift_wr = 1'b1;
          if (stat_i.idx_end) begin
            ctrl_o.del_done = 1'b1;
          end else begin
            ctrl_o.idx_inc = 1'b1;
            ctrl_o.rd_req  = 1'b1;
          end
        end
      end
      bmle_pkg::S_COPY: begin
        if (stat_i.rd_valid) begin
          ctrl_o.buf_wr = 1'b1;
          if (stat_i.idx_end) begin
            ctrl_o.sort_init = 1'b1;
            ctrl_o.idx_clr   = 1'b1;
          end else begin
            ctrl_o.idx_inc = 1'b1;
            ctrl_o.rd_req  = 1'b1;
          end
        end
      end
      bmle_pkg::S_SORT: ctrl_o.sort_step = 1'b1;
      bmle_pkg::S_EMIT: ctrl_o.emit = 1'b1;
      default: ctrl_o = '0;
    endcase
  end

endmodule

### src/bmle_dp.sv
// Datapath for the bounded multi-list engine: list table, element memory,
// sort buffer and result register. Depends on bmle_pkg.
module bmle_dp #(
  parameter int NumLists    = bmle_pkg::NumListsDefault,
  parameter int MaxCapacity = bmle_pkg::MaxCapacityDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bmle_pkg::ctrl_t       ctrl_i,
  output bmle_pkg::stat_t       stat_o,
  input  logic [2:0]            opcode_i,
  input  logic [3:0]            list_number_i,
  input  logic signed [31:0]    value_i,
  input  logic signed [6:0]     amount_i,
  output logic                  result_valid_o,
  output logic [3:0]            status_o,
  output logic [4:0]            fill_count_o,
  output logic signed [31:0]    data_o,
  output logic                  last_o
);

  localparam int SlotW = (NumLists > 1) ? $clog2(NumLists) : 1;
  localparam int IdxW  = (MaxCapacity > 1) ? $clog2(MaxCapacity) : 1;
  localparam int CntW  = $clog2(MaxCapacity + 1);
  localparam int Depth = NumLists * MaxCapacity;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Item latched at start.
  logic [2:0]         op_q;
  logic [3:0]         num_q;
  logic signed [31:0] val_q;
  logic signed [6:0]  amt_q;

  logic              exists_q [NumLists];
  logic [CntW-1:0]   fill_q   [NumLists];
  logic [CntW-1:0]   cap_q    [NumLists];

  logic [31:0]       mem [Depth];
  logic [31:0]       rdata_q;
  logic              rvalid_q;

  logic [IdxW-1:0]   idx_q;
  logic [31:0]       buf_q [MaxCapacity];
  logic [IdxW-1:0]   si_q, sj_q;

  logic [3:0]        res_status_q, res_status_d;
  logic [4:0]        res_fill_q, res_fill_d;
  logic [31:0]       res_data_q, res_data_d;
  logic              res_last_q, res_last_d;
  logic              res_valid_q;

  // Slot and list lookup.
  logic              pos_ok;
  logic [SlotW-1:0]  slot;
  logic              ex;
  logic [CntW-1:0]   fill, cap;
  logic [AddrW-1:0]  base;
  logic signed [8:0] newsize;
  logic [4:0]        fill5;
  logic signed [8:0] amt9;

  assign pos_ok = (num_q != 4'd0) && ({4'd0, num_q} <= 8'(NumLists));
  assign slot   = SlotW'(num_q - 4'd1);
  assign ex     = pos_ok ? exists_q[slot] : 1'b0;
  assign fill   = pos_ok ? fill_q[slot] : '0;
  assign cap    = pos_ok ? cap_q[slot] : '0;
  assign base   = AddrW'(slot * MaxCapacity);
  assign newsize = 9'(signed'({1'b0, cap})) + 9'(amt_q);
  assign fill5  = 5'(fill);
  assign amt9   = 9'(amt_q);

  logic multi;
  assign multi = pos_ok && ex && (fill != '0) &&
                 (op_q == bmle_pkg::OpDelete || op_q == bmle_pkg::OpRead ||
                  op_q == bmle_pkg::OpSorted);

  logic [IdxW-1:0] last_idx;
  assign last_idx = IdxW'(fill - CntW'(1));

  assign stat_o.op       = op_q;
  assign stat_o.go_multi = multi;
  assign stat_o.match    = (rdata_q == val_q);
  assign stat_o.rd_valid = rvalid_q;
  assign stat_o.idx_end  = (idx_q == last_idx);
  // A single entry needs no compare, so the sort ends at once.
  assign stat_o.sort_end = (fill <= CntW'(1)) ||
                           ((sj_q == last_idx) &&
                            (si_q == IdxW'(fill - CntW'(2))));
  assign stat_o.emit_end = (idx_q == last_idx);

  // Sort compare in signed order.
  logic swap;
  assign swap = $signed(buf_q[si_q]) > $signed(buf_q[sj_q]);

  always_comb begin
    res_status_d = bmle_pkg::StOk;
    res_fill_d   = fill5;
    res_data_d   = '0;
    res_last_d   = 1'b1;
    if (ctrl_i.decide) begin
      if (!pos_ok) begin
        res_status_d = bmle_pkg::StBadPos;
        res_fill_d   = '0;
      end else if (op_q == bmle_pkg::OpCreate) begin
        if (ex) begin
          res_status_d = bmle_pkg::StExists;
        end else if (amt_q < 7'sd1) begin
          res_status_d = bmle_pkg::StBadSize;
          res_fill_d   = '0;
        end else if (amt9 > 9'(MaxCapacity)) begin
          res_status_d = bmle_pkg::StNoMemory;
          res_fill_d   = '0;
        end else begin
          res_fill_d   = '0;
        end
      end else if (!ex) begin
        res_status_d = bmle_pkg::StNoList;
        res_fill_d   = '0;
      end else begin
        case (op_q)
          bmle_pkg::OpAppend: begin
            if (fill >= cap) res_status_d = bmle_pkg::StFull;
            else res_fill_d = fill5 + 5'd1;
          end
          bmle_pkg::OpPop, bmle_pkg::OpDelete: begin
            if (fill == '0) res_status_d = bmle_pkg::StEmpty;
            else if (op_q == bmle_pkg::OpPop) res_fill_d = fill5 - 5'd1;
          end
          bmle_pkg::OpResize: begin
            if (newsize < 9'sd1) res_status_d = bmle_pkg::StBadNewSize;
            else if (newsize > 9'(MaxCapacity)) res_status_d = bmle_pkg::StNoMemory;
            else if ({4'd0, fill5} > newsize) res_fill_d = 5'(newsize);
          end
          default: res_fill_d = fill5;
        endcase
      end
    end
    if (ctrl_i.nf_emit) res_status_d = bmle_pkg::StNotFound;
    if (ctrl_i.del_done) res_fill_d = fill5 - 5'd1;
    if (ctrl_i.emit) begin
      res_data_d = buf_q[idx_q];
      res_last_d = (idx_q == last_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      op_q  <= opcode_i;
      num_q <= list_number_i;
      val_q <= value_i;
      amt_q <= amount_i;
    end
    if (ctrl_i.idx_clr) begin
      idx_q <= '0;
    end else if (ctrl_i.idx_inc || ctrl_i.emit) begin
      idx_q <= idx_q + IdxW'(1);
    end
    // Element memory: one read, one write per cycle.
    if (ctrl_i.rd_req) begin
      rdata_q <= mem[base + AddrW'(ctrl_i.idx_inc ? idx_q + IdxW'(1) : '0)];
    end
    if (ctrl_i.decide && pos_ok && ex && op_q == bmle_pkg::OpAppend &&
        fill < cap) begin
      mem[base + AddrW'(fill)] <= val_q;
    end
    if (ctrl_i.shift_wr) begin
      mem[base + AddrW'(idx_q) - AddrW'(1)] <= rdata_q;
    end
    if (ctrl_i.buf_wr) begin
      buf_q[idx_q] <= rdata_q;
    end
    if (ctrl_i.sort_init) begin
      si_q <= '0;
      sj_q <= IdxW'(1);
    end else if (ctrl_i.sort_step && fill > CntW'(1)) begin
      if (swap) begin
        buf_q[si_q] <= buf_q[sj_q];
        buf_q[sj_q] <= buf_q[si_q];
      end
      if (sj_q == last_idx) begin
        si_q <= si_q + IdxW'(1);
        sj_q <= si_q + IdxW'(2);
      end else begin
        sj_q <= sj_q + IdxW'(1);
      end
    end
    res_status_q <= res_status_d;
    res_fill_q   <= res_fill_d;
    res_data_q   <= res_data_d;
    res_last_q   <= res_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q    <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < NumLists; i++) begin
        exists_q[i] <= 1'b0;
        fill_q[i]   <= '0;
        cap_q[i]    <= '0;
      end
    end else begin
      rvalid_q    <= ctrl_i.rd_req;
      res_valid_q <= (ctrl_i.decide && !multi) || ctrl_i.nf_emit ||
                     ctrl_i.del_done || ctrl_i.emit;
      if (ctrl_i.decide && pos_ok) begin
        if (op_q == bmle_pkg::OpCreate && !ex && amt_q >= 7'sd1 &&
            amt9 <= 9'(MaxCapacity)) begin
          exists_q[slot] <= 1'b1;
          cap_q[slot]    <= CntW'(amt_q);
          fill_q[slot]   <= '0;
        end else if (ex && op_q == bmle_pkg::OpAppend && fill < cap) begin
          fill_q[slot] <= fill + CntW'(1);
        end else if (ex && op_q == bmle_pkg::OpPop && fill != '0) begin
          fill_q[slot] <= fill - CntW'(1);
        end else if (ex && op_q == bmle_pkg::OpResize && newsize >= 9'sd1 &&
                     newsize <= 9'(MaxCapacity)) begin
          cap_q[slot] <= CntW'(newsize);
          if ({4'd0, fill5} > newsize) fill_q[slot] <= CntW'(newsize);
        end
      end
      if (ctrl_i.del_done) fill_q[slot] <= fill - CntW'(1);
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign fill_count_o   = res_fill_q;
  assign data_o         = res_data_q;
  assign last_o         = res_last_q;

endmodule

### tb/testbench.sv
// Self-checking testbench for the bounded multi-list engine.
// Depends on bmle_pkg and bounded_multi_list_engine; predicts every result
// from a behavioral copy of the list store and checks each strobed result.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLists = 10;
  localparam int MaxCap = 16;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         num;
    logic signed [31:0] value;
    logic signed [6:0]  amount;
  } list_cmd_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [4:0]         fill;
    logic signed [31:0] data;
    logic               last;
  } list_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] opcode_i = '0;
  logic [3:0] list_number_i = '0;
  logic signed [31:0] value_i = '0;
  logic signed [6:0] amount_i = '0;
  logic result_valid_o;
  logic [3:0] status_o;
  logic [4:0] fill_count_o;
  logic signed [31:0] data_o;
  logic last_o;

  list_cmd_t   cmd_queue[$];
  list_reply_t reply_queue[$];
  int errors = 0;
  int watchdog = 0;
  bit quiet_driver = 1'b0;
  bit hold_sender = 1'b0;

  // Shadow copy of the list store.
  logic signed [31:0] shadow_elems[NLists][MaxCap];
  int shadow_fill[NLists];
  int shadow_cap[NLists];
  bit shadow_exists[NLists];

  always #5 clk_i = ~clk_i;

  bounded_multi_list_engine u_dut (.*);

  function automatic list_reply_t mk_reply(logic [3:0] st, int fill,
                                           logic signed [31:0] d, logic l);
    list_reply_t r;
    r.status = st;
    r.fill = fill[4:0];
    r.data = d;
    r.last = l;
    return r;
  endfunction

  task automatic predict_lists(list_cmd_t c);
    int slot;
    int fill;
    int idx;
    int new_cap;
    int amt;
    logic signed [31:0] tmp;
    logic signed [31:0] sbuf[MaxCap];
    amt = int'(c.amount);
    if (c.num < 1 || c.num > NLists) begin
      reply_queue.push_back(mk_reply(bmle_pkg::StBadPos, 0, 0, 1'b1));
      return;
    end
    slot = c.num - 1;
    if (c.op == bmle_pkg::OpCreate) begin
      if (shadow_exists[slot]) begin
        reply_queue.push_back(mk_reply(bmle_pkg::StExists, shadow_fill[slot], 0, 1'b1));
      end else if (amt < 1) begin
        reply_queue.push_back(mk_reply(bmle_pkg::StBadSize, 0, 0, 1'b1));
      end else if (amt > MaxCap) begin
        reply_queue.push_back(mk_reply(bmle_pkg::StNoMemory, 0, 0, 1'b1));
      end else begin
        shadow_exists[slot] = 1'b1;
        shadow_cap[slot] = amt;
        shadow_fill[slot] = 0;
        reply_queue.push_back(mk_reply(bmle_pkg::StOk, 0, 0, 1'b1));
      end
      return;
    end
    if (!shadow_exists[slot]) begin
      reply_queue.push_back(mk_reply(bmle_pkg::StNoList, 0, 0, 1'b1));
      return;
    end
    fill = shadow_fill[slot];
    case (c.op)
      bmle_pkg::OpAppend: begin
        if (fill >= shadow_cap[slot]) begin
          reply_queue.push_back(mk_reply(bmle_pkg::StFull, fill, 0, 1'b1));
        end else begin
          shadow_elems[slot][fill] = c.value;
          shadow_fill[slot] = fill + 1;
          reply_queue.push_back(mk_reply(bmle_pkg::StOk, fill + 1, 0, 1'b1));
        end
      end
      bmle_pkg::OpPop: begin
        if (fill == 0) begin
          reply_queue.push_back(mk_reply(bmle_pkg::StEmpty, 0, 0, 1'b1));
        end else begin
          shadow_fill[slot] = fill - 1;
          reply_queue.push_back(mk_reply(bmle_pkg::StOk, fill - 1, 0, 1'b1));
        end
      end
      bmle_pkg::OpDelete: begin
        idx = 0;
        while (idx < fill && shadow_elems[slot][idx] != c.value) idx++;
        if (fill == 0) begin
          reply_queue.push_back(mk_reply(bmle_pkg::StEmpty, 0, 0, 1'b1));
        end else if (idx == fill) begin
          reply_queue.push_back(mk_reply(bmle_pkg::StNotFound, fill, 0, 1'b1));
        end else begin
          for (int i = idx; i + 1 < fill; i++)
            shadow_elems[slot][i] = shadow_elems[slot][i + 1];
          shadow_fill[slot] = fill - 1;
          reply_queue.push_back(mk_reply(bmle_pkg::StOk, fill - 1, 0, 1'b1));
        end
      end
      bmle_pkg::OpResize: begin
        new_cap = shadow_cap[slot] + amt;
        if (new_cap < 1) begin
          reply_queue.push_back(mk_reply(bmle_pkg::StBadNewSize, fill, 0, 1'b1));
        end else if (new_cap > MaxCap) begin
          reply_queue.push_back(mk_reply(bmle_pkg::StNoMemory, fill, 0, 1'b1));
        end else begin
          shadow_cap[slot] = new_cap;
          if (fill > new_cap) fill = new_cap;
          shadow_fill[slot] = fill;
          reply_queue.push_back(mk_reply(bmle_pkg::StOk, fill, 0, 1'b1));
        end
      end
      bmle_pkg::OpCount: reply_queue.push_back(mk_reply(bmle_pkg::StOk, fill, 0, 1'b1));
      default: begin
        if (fill == 0) begin
          reply_queue.push_back(mk_reply(bmle_pkg::StOk, 0, 0, 1'b1));
        end else begin
          for (int i = 0; i < fill; i++) sbuf[i] = shadow_elems[slot][i];
          if (c.op == bmle_pkg::OpSorted) begin
            for (int k = 0; k + 1 < fill; k++)
              for (int j = k + 1; j < fill; j++)
                if (sbuf[k] > sbuf[j]) begin
                  tmp = sbuf[k];
                  sbuf[k] = sbuf[j];
                  sbuf[j] = tmp;
                end
          end
          for (int i = 0; i < fill; i++)
            reply_queue.push_back(mk_reply(bmle_pkg::StOk, fill, sbuf[i], i + 1 == fill));
        end
      end
    endcase
  endtask

  function automatic list_cmd_t mk_cmd(logic [2:0] op, logic [3:0] num,
                                       logic signed [31:0] v, logic signed [6:0] a);
    list_cmd_t c;
    c.op = op;
    c.num = num;
    c.value = v;
    c.amount = a;
    return c;
  endfunction

  // Driver: presents queued items and idles about 29% of the time unless quiet_driver is set.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_lists({opcode_i, list_number_i, value_i, amount_i});
      end
      if (!(start && busy)) begin
        if (cmd_queue.size() > 0 && !hold_sender &&
            (quiet_driver || $urandom_range(99) >= 29)) begin
          list_cmd_t c;
          c = cmd_queue.pop_front();
          start <= 1'b1;
          opcode_i <= c.op;
          list_number_i <= c.num;
          value_i <= c.value;
          amount_i <= c.amount;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk_i) begin
    list_reply_t exp_r;
    if (rst_ni) begin
      if (result_valid_o) begin
        watchdog <= 0;
        if (reply_queue.size() == 0) begin
          $error("unexpected result: status %0d fill %0d", status_o, fill_count_o);
          errors++;
        end else begin
          exp_r = reply_queue.pop_front();
          if (status_o !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, status_o);
            errors++;
          end
          if (fill_count_o !== exp_r.fill) begin
            $error("fill_count expected %0d actual %0d", exp_r.fill, fill_count_o);
            errors++;
          end
          if (data_o !== exp_r.data) begin
            $error("data expected %0d actual %0d", exp_r.data, data_o);
            errors++;
          end
          if (last_o !== exp_r.last) begin
            $error("last expected %0d actual %0d", exp_r.last, last_o);
            errors++;
          end
        end
      end else if (start && !busy) begin
        watchdog <= 0;
      end else begin
        watchdog <= watchdog + 1;
      end
      if (watchdog >= WatchdogLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed(32'($urandom_range(7)) - 32'd3);
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic drain_all();
    while (cmd_queue.size() > 0 || start || busy || reply_queue.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int lst;
    int fill_goal;
    for (int s = 0; s < NLists; s++) begin
      shadow_fill[s] = 0;
      shadow_cap[s] = 0;
      shadow_exists[s] = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bad positions, missing list, size errors, full/empty paths.
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCount, 4'd0, 0, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpAppend, 4'd15, 32'sh7fff_ffff, 7'sd32));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpRead, 4'd11, 0, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpPop, 4'd1, 0, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCreate, 4'd1, 0, -7'sd32));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCreate, 4'd1, 0, 7'sd0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCreate, 4'd1, 0, 7'sd17));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCreate, 4'd1, 0, 7'sd32));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCreate, 4'd1, 0, 7'sd2));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCreate, 4'd1, 0, 7'sd3));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpRead, 4'd1, 0, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpPop, 4'd1, 0, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpDelete, 4'd1, 5, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpAppend, 4'd1, 32'sh7fff_ffff, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpAppend, 4'd1, 32'sh8000_0000, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpAppend, 4'd1, 1, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpSorted, 4'd1, 0, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpDelete, 4'd1, 9, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpDelete, 4'd1, 32'sh7fff_ffff, 0));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpResize, 4'd1, 0, -7'sd32));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpResize, 4'd1, 0, 7'sd32));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpResize, 4'd1, 0, -7'sd1));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpResize, 4'd1, 0, 7'sd14));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCreate, 4'd10, 0, 7'sd16));
    cmd_queue.push_back(mk_cmd(bmle_pkg::OpCount, 4'd1, 0, 0));
    quiet_driver = 1'b1;
    drain_all();

    // Sender holds off after all results are back, while hold_sender is set.
    hold_sender = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b0;
    quiet_driver = 1'b0;

    // Random: mostly fill-and-walk sequences on valid lists, some noise.
    for (int n = 0; n < 145; ) begin
      lst = $urandom_range(1, NLists);
      if ($urandom_range(9) == 0) begin
        cmd_queue.push_back(mk_cmd(3'($urandom()), 4'($urandom()), rand_word(),
                                   7'($urandom_range(64) - 32)));
        n++;
      end else begin
        cmd_queue.push_back(mk_cmd(bmle_pkg::OpCreate, 4'(lst), 0,
                                   7'($urandom_range(1, 16))));
        fill_goal = $urandom_range(0, 6);
        for (int k = 0; k < fill_goal; k++)
          cmd_queue.push_back(mk_cmd(bmle_pkg::OpAppend, 4'(lst), rand_word(), 0));
        cmd_queue.push_back(mk_cmd(3'($urandom_range(2, 7)), 4'(lst), rand_word(),
                                   7'($urandom_range(64) - 32)));
        cmd_queue.push_back(mk_cmd(bmle_pkg::OpSorted, 4'(lst), 0, 0));
        n += fill_goal + 3;
      end
      if (n > 50 && n < 100) quiet_driver = 1'b1;
      else quiet_driver = 1'b0;
      while (cmd_queue.size() > 8) @(posedge clk_i);
    end
    drain_all();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
